// ===== src/wkm_pkg.sv =====
// Shared types and constants of the weighted k-way n-gram merge.
package wkm_pkg;

    localparam int NUM_STREAMS_DEF = 4;
    localparam int MAX_WORDS_DEF   = 4;
    localparam int WORD_BITS_DEF   = 16;

    localparam int PORT_WORDS  = 4;
    localparam int KEY_W       = 16;
    localparam int COUNT_W     = 32;
    localparam int WEIGHT_W    = 16;
    localparam int STREAM_W    = 2;
    localparam int MASK_W      = 4;
    localparam int NW_W        = 3;
    localparam int NS_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ROUND_SHIFT = 8;
    localparam int NUM_WEIGHTS = 4;

    localparam logic [NW_W-1:0]     NW_RST     = 3'd3;
    localparam logic [NS_W-1:0]     NS_RST     = 3'd4;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;
    localparam logic [ROUND_SHIFT-1:0] ROUND_ADD = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NGRAM_WORDS  = 3'd0,
        CFG_STREAMS_USED = 3'd1,
        CFG_WEIGHT_0     = 3'd2,
        CFG_WEIGHT_1     = 3'd3,
        CFG_WEIGHT_2     = 3'd4,
        CFG_WEIGHT_3     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic cmp;
        logic acc;
        logic idx_inc;
        logic emit_rec;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic all_ready;
        logic all_ended;
        logic done_sent;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

// ===== src/weighted_kway_ngram_merge_top.sv =====
// Top level of the weighted k-way n-gram merge.
// Input records arrive as valid/ready transactions, each carrying one stream's
// next record or its end mark. Records for unused streams, for a stream that
// already holds a head, or for an ended stream are taken and dropped.
// Once every active stream holds a head or has ended, the block scans the
// heads, finds the smallest key, sums count times weight and emits one result
// transaction with the key, the rounded count and the refill mask.
// When all active streams have ended it emits one final done transaction and
// then drops all further input until reset.
// An input transaction that completes no merge passes the check state and
// returns to idle; a merging one scans the heads, streams_used clamped to
// 1..NUM_STREAMS, in one read, compare and accumulate step per head through
// the single read port of the head memory, then loads the output register.
// The done transaction skips the scan. No new input is taken until the block
// is back in idle. The output register holds a result until the receiver takes
// it; while it is stalled the block finishes the scan and waits before loading
// the next result. Reset is synchronous and active low: it restores the
// configuration defaults, clears all heads and end marks, and empties the
// output register. Configuration is written through a plain write port; the
// user must write it only while idle; the block itself does not enforce this.
module weighted_kway_ngram_merge_top #(
    parameter int NUM_STREAMS = wkm_pkg::NUM_STREAMS_DEF,
    parameter int MAX_WORDS   = wkm_pkg::MAX_WORDS_DEF,
    parameter int WORD_BITS   = wkm_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wkm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wkm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wkm_pkg::STREAM_W-1:0]   i_stream,
    input  logic                           i_end_of_stream,
    input  logic [wkm_pkg::KEY_W-1:0]      i_key_word_0,
    input  logic [wkm_pkg::KEY_W-1:0]      i_key_word_1,
    input  logic [wkm_pkg::KEY_W-1:0]      i_key_word_2,
    input  logic [wkm_pkg::KEY_W-1:0]      i_key_word_3,
    input  logic [wkm_pkg::COUNT_W-1:0]    i_record_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [wkm_pkg::KEY_W-1:0]      o_out_word_0,
    output logic [wkm_pkg::KEY_W-1:0]      o_out_word_1,
    output logic [wkm_pkg::KEY_W-1:0]      o_out_word_2,
    output logic [wkm_pkg::KEY_W-1:0]      o_out_word_3,
    output logic [wkm_pkg::COUNT_W-1:0]    o_merged_count,
    output logic                           o_overflow,
    output logic [wkm_pkg::MASK_W-1:0]     o_refill_mask,
    output logic                           o_all_done
);

    wkm_pkg::t_cmd    w_cmd;
    wkm_pkg::t_status w_status;

    wkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wkm_datapath #(
        .NUM_STREAMS (NUM_STREAMS),
        .MAX_WORDS   (MAX_WORDS),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_stream        (i_stream),
        .i_end_of_stream (i_end_of_stream),
        .i_key_word_0    (i_key_word_0),
        .i_key_word_1    (i_key_word_1),
        .i_key_word_2    (i_key_word_2),
        .i_key_word_3    (i_key_word_3),
        .i_record_count  (i_record_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_word_0    (o_out_word_0),
        .o_out_word_1    (o_out_word_1),
        .o_out_word_2    (o_out_word_2),
        .o_out_word_3    (o_out_word_3),
        .o_merged_count  (o_merged_count),
        .o_overflow      (o_overflow),
        .o_refill_mask   (o_refill_mask),
        .o_all_done      (o_all_done)
    );

endmodule

// ===== src/wkm_ctrl.sv =====
// Controller state machine that sequences the head scan and result emission.
module wkm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wkm_pkg::t_status i_status,
    output wkm_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_CMP,
        S_ACC,
        S_EMIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.done_sent || !i_status.all_ready) begin
                    n_state = S_IDLE;
                end else if (i_status.all_ended) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_rec = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/wkm_datapath.sv =====
// Datapath with configuration, head memory, key compare, weighted sum and output register.
module wkm_datapath #(
    parameter int NUM_STREAMS = wkm_pkg::NUM_STREAMS_DEF,
    parameter int MAX_WORDS   = wkm_pkg::MAX_WORDS_DEF,
    parameter int WORD_BITS   = wkm_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wkm_pkg::t_cmd                    i_cmd,
    output wkm_pkg::t_status                 o_status,
    input  logic                             i_cfg_we,
    input  logic [wkm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wkm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [wkm_pkg::STREAM_W-1:0]     i_stream,
    input  logic                             i_end_of_stream,
    input  logic [wkm_pkg::KEY_W-1:0]        i_key_word_0,
    input  logic [wkm_pkg::KEY_W-1:0]        i_key_word_1,
    input  logic [wkm_pkg::KEY_W-1:0]        i_key_word_2,
    input  logic [wkm_pkg::KEY_W-1:0]        i_key_word_3,
    input  logic [wkm_pkg::COUNT_W-1:0]      i_record_count,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [wkm_pkg::KEY_W-1:0]        o_out_word_0,
    output logic [wkm_pkg::KEY_W-1:0]        o_out_word_1,
    output logic [wkm_pkg::KEY_W-1:0]        o_out_word_2,
    output logic [wkm_pkg::KEY_W-1:0]        o_out_word_3,
    output logic [wkm_pkg::COUNT_W-1:0]      o_merged_count,
    output logic                             o_overflow,
    output logic [wkm_pkg::MASK_W-1:0]       o_refill_mask,
    output logic                             o_all_done
);

    localparam int SW        = $clog2(NUM_STREAMS);
    localparam int KEY_ROW_W = MAX_WORDS * WORD_BITS;
    localparam int ROW_W     = KEY_ROW_W + wkm_pkg::COUNT_W;
    localparam int PROD_W    = wkm_pkg::COUNT_W + wkm_pkg::WEIGHT_W;
    localparam int SUM_W     = PROD_W + SW;
    localparam int CNT_W     = SUM_W + 1 - wkm_pkg::ROUND_SHIFT;
    localparam int PW        = wkm_pkg::PORT_WORDS;
    localparam int KW        = wkm_pkg::KEY_W;

    logic [wkm_pkg::NW_W-1:0]     r_ngram_words;
    logic [wkm_pkg::NS_W-1:0]     r_streams_used;
    logic [wkm_pkg::WEIGHT_W-1:0] r_weight [wkm_pkg::NUM_WEIGHTS];

    logic [NUM_STREAMS-1:0] r_head_valid;
    logic [NUM_STREAMS-1:0] r_ended;
    logic                   r_done_sent;
    logic [ROW_W-1:0]       r_mem [NUM_STREAMS];
    logic [ROW_W-1:0]       r_rd_row;
    logic [SW-1:0]          r_idx;
    logic                   r_lt;
    logic                   r_eq;
    logic                   r_row_valid;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_any;
    logic [KEY_ROW_W-1:0]   r_min_key;
    logic [NUM_STREAMS-1:0] r_mask;
    logic [SUM_W-1:0]       r_sum;

    logic          r_out_valid;
    logic [KW-1:0] r_out_word [PW];
    logic [wkm_pkg::COUNT_W-1:0] r_out_count;
    logic          r_out_overflow;
    logic [wkm_pkg::MASK_W-1:0] r_out_mask;
    logic          r_out_done;

    logic [wkm_pkg::NW_W-1:0] w_nw;
    logic [SW-1:0]            w_last;
    logic [NUM_STREAMS-1:0]   w_used;
    logic                     w_s_ok;
    logic [SW-1:0]            w_sel;
    logic                     w_elig;
    logic [KW-1:0]            w_port_key [PW];
    logic [KEY_ROW_W-1:0]     w_in_key;
    logic [KEY_ROW_W-1:0]     w_cand_cmp;
    logic [KEY_ROW_W-1:0]     w_best_cmp;
    logic [SUM_W:0]           w_round;
    logic [CNT_W-1:0]         w_cnt;
    logic                     w_ovf;
    logic [KW-1:0]            w_key_word [PW];
    logic [NUM_STREAMS-1:0]   w_idx_bit;
    logic                     w_out_free;

    always_comb begin
        if (r_ngram_words == '0) begin
            w_nw = wkm_pkg::NW_W'(1);
        end else if (int'(r_ngram_words) > MAX_WORDS) begin
            w_nw = wkm_pkg::NW_W'(MAX_WORDS);
        end else begin
            w_nw = r_ngram_words;
        end
        if (r_streams_used == '0) begin
            w_last = '0;
        end else if (int'(r_streams_used) >= NUM_STREAMS) begin
            w_last = SW'(NUM_STREAMS - 1);
        end else begin
            w_last = SW'(r_streams_used - 3'd1);
        end
        for (int i = 0; i < NUM_STREAMS; i++) begin
            w_used[i] = (i <= int'(w_last));
        end
    end

    assign w_port_key[0] = i_key_word_0;
    assign w_port_key[1] = i_key_word_1;
    assign w_port_key[2] = i_key_word_2;
    assign w_port_key[3] = i_key_word_3;

    always_comb begin
        for (int w = 0; w < MAX_WORDS; w++) begin
            w_in_key[w*WORD_BITS +: WORD_BITS] = WORD_BITS'(w_port_key[w]);
        end
    end

    assign w_s_ok = (int'(i_stream) <= int'(w_last));
    assign w_sel  = i_stream[SW-1:0];
    assign w_elig = i_cmd.load && !r_done_sent && w_s_ok
                    && !r_head_valid[w_sel] && !r_ended[w_sel];

    // Keys are laid out with word 0 most significant and unused words zeroed.
    always_comb begin
        for (int w = 0; w < MAX_WORDS; w++) begin
            if (w < int'(w_nw)) begin
                w_cand_cmp[(MAX_WORDS-1-w)*WORD_BITS +: WORD_BITS] =
                    r_rd_row[w*WORD_BITS +: WORD_BITS];
                w_best_cmp[(MAX_WORDS-1-w)*WORD_BITS +: WORD_BITS] =
                    r_min_key[w*WORD_BITS +: WORD_BITS];
            end else begin
                w_cand_cmp[(MAX_WORDS-1-w)*WORD_BITS +: WORD_BITS] = '0;
                w_best_cmp[(MAX_WORDS-1-w)*WORD_BITS +: WORD_BITS] = '0;
            end
        end
        for (int i = 0; i < NUM_STREAMS; i++) begin
            w_idx_bit[i] = (i == int'(r_idx));
        end
    end

    genvar g;
    generate
        for (g = 0; g < PW; g++) begin : g_out_word
            if (g < MAX_WORDS) begin : g_used
                assign w_key_word[g] = (g < int'(w_nw))
                    ? KW'(r_min_key[g*WORD_BITS +: WORD_BITS]) : '0;
            end else begin : g_unused
                assign w_key_word[g] = '0;
            end
        end
    endgenerate

    assign w_round = (SUM_W+1)'(r_sum) + (SUM_W+1)'(wkm_pkg::ROUND_ADD);
    assign w_cnt   = w_round[SUM_W:wkm_pkg::ROUND_SHIFT];
    assign w_ovf   = |w_cnt[CNT_W-1:wkm_pkg::COUNT_W];

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ngram_words  <= wkm_pkg::NW_RST;
            r_streams_used <= wkm_pkg::NS_RST;
            for (int i = 0; i < wkm_pkg::NUM_WEIGHTS; i++) begin
                r_weight[i] <= wkm_pkg::WEIGHT_RST;
            end
        end else if (i_cfg_we) begin
            case (wkm_pkg::t_cfg_idx'(i_cfg_idx))
                wkm_pkg::CFG_NGRAM_WORDS:  r_ngram_words  <= i_cfg_wdata[wkm_pkg::NW_W-1:0];
                wkm_pkg::CFG_STREAMS_USED: r_streams_used <= i_cfg_wdata[wkm_pkg::NS_W-1:0];
                wkm_pkg::CFG_WEIGHT_0:     r_weight[0]    <= i_cfg_wdata;
                wkm_pkg::CFG_WEIGHT_1:     r_weight[1]    <= i_cfg_wdata;
                wkm_pkg::CFG_WEIGHT_2:     r_weight[2]    <= i_cfg_wdata;
                wkm_pkg::CFG_WEIGHT_3:     r_weight[3]    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_elig && !i_end_of_stream) begin
            r_mem[w_sel] <= {i_record_count, w_in_key};
        end
        if (i_cmd.rd) begin
            r_rd_row <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_lt   <= (w_cand_cmp < w_best_cmp);
            r_eq   <= (w_cand_cmp == w_best_cmp);
            r_prod <= PROD_W'(r_rd_row[ROW_W-1 -: wkm_pkg::COUNT_W])
                      * PROD_W'(r_weight[2'(r_idx)]);
        end
        if (i_cmd.acc && r_row_valid) begin
            if (!r_any || r_lt) begin
                r_min_key <= r_rd_row[KEY_ROW_W-1:0];
                r_sum     <= SUM_W'(r_prod);
            end else if (r_eq) begin
                r_sum     <= r_sum + SUM_W'(r_prod);
            end
        end
        if (i_cmd.emit_rec) begin
            for (int w = 0; w < PW; w++) begin
                r_out_word[w] <= w_key_word[w];
            end
            r_out_count    <= w_ovf ? '1 : w_cnt[wkm_pkg::COUNT_W-1:0];
            r_out_overflow <= w_ovf;
            r_out_mask     <= wkm_pkg::MASK_W'(r_mask);
            r_out_done     <= 1'b0;
        end else if (i_cmd.emit_done) begin
            for (int w = 0; w < PW; w++) begin
                r_out_word[w] <= '0;
            end
            r_out_count    <= '0;
            r_out_overflow <= 1'b0;
            r_out_mask     <= '0;
            r_out_done     <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_ended      <= '0;
            r_done_sent  <= 1'b0;
            r_idx        <= '0;
            r_any        <= 1'b0;
            r_mask       <= '0;
            r_row_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_elig) begin
                if (i_end_of_stream) begin
                    r_ended[w_sel] <= 1'b1;
                end else begin
                    r_head_valid[w_sel] <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_idx <= '0;
                r_any <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.cmp) begin
                r_row_valid <= r_head_valid[r_idx];
            end
            if (i_cmd.acc && r_row_valid) begin
                r_any <= 1'b1;
                if (!r_any || r_lt) begin
                    r_mask <= w_idx_bit;
                end else if (r_eq) begin
                    r_mask <= r_mask | w_idx_bit;
                end
            end
            if (i_cmd.emit_rec) begin
                r_head_valid <= r_head_valid & ~r_mask;
            end
            if (i_cmd.emit_done) begin
                r_done_sent <= 1'b1;
            end
            if (i_cmd.emit_rec || i_cmd.emit_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.all_ready = &(~w_used | r_ended | r_head_valid);
    assign o_status.all_ended = &(~w_used | r_ended);
    assign o_status.done_sent = r_done_sent;
    assign o_status.idx_last  = (r_idx == w_last);
    assign o_status.out_free  = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_out_word_0   = r_out_word[0];
    assign o_out_word_1   = r_out_word[1];
    assign o_out_word_2   = r_out_word[2];
    assign o_out_word_3   = r_out_word[3];
    assign o_merged_count = r_out_count;
    assign o_overflow     = r_out_overflow;
    assign o_refill_mask  = r_out_mask;
    assign o_all_done     = r_out_done;

endmodule

// ===== src/wkm_checker.sv =====
// Port-level assertion checker for the merge top level and its bind statement.
module wkm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [wkm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [wkm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [wkm_pkg::STREAM_W-1:0]   i_stream,
    input logic                           i_end_of_stream,
    input logic [wkm_pkg::KEY_W-1:0]      i_key_word_0,
    input logic [wkm_pkg::KEY_W-1:0]      i_key_word_1,
    input logic [wkm_pkg::KEY_W-1:0]      i_key_word_2,
    input logic [wkm_pkg::KEY_W-1:0]      i_key_word_3,
    input logic [wkm_pkg::COUNT_W-1:0]    i_record_count,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [wkm_pkg::KEY_W-1:0]      o_out_word_0,
    input logic [wkm_pkg::KEY_W-1:0]      o_out_word_1,
    input logic [wkm_pkg::KEY_W-1:0]      o_out_word_2,
    input logic [wkm_pkg::KEY_W-1:0]      o_out_word_3,
    input logic [wkm_pkg::COUNT_W-1:0]    o_merged_count,
    input logic                           o_overflow,
    input logic [wkm_pkg::MASK_W-1:0]     o_refill_mask,
    input logic                           o_all_done
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_merged_count)
            && $stable(o_refill_mask) && $stable(o_all_done))
        else $error("stalled output transaction changed");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_all_done |-> o_refill_mask == '0 && o_merged_count == '0
            && !o_overflow && o_out_word_0 == '0)
        else $error("done transaction carries data");

    a_rec_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_all_done |-> o_refill_mask != '0)
        else $error("merged record without consumed stream");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_merged_count == '1)
        else $error("overflow without saturated count");

endmodule

bind weighted_kway_ngram_merge_top wkm_checker u_wkm_checker (.*);
